>>> design/rsc_pkg.sv
// Shared types, constants and helper functions for the radix string converter.
package rsc_pkg;

  // Payload of one input request.
  typedef struct packed {
    logic [7:0] digit_char;
    logic       last_in;
  } rsc_in_t;

  // Payload of one output request.
  typedef struct packed {
    logic [6:0] out_char;
    logic       last_out;
  } rsc_out_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    RSC_IDLE,
    RSC_DIV,
    RSC_RD,
    RSC_WR
  } rsc_state_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgInBase  = 2'd0;
  localparam logic [1:0] CfgOutBase = 2'd1;

  localparam int unsigned BaseW = 6;
  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] BaseMin   = 6'd2;

  // Character constants.
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'h20;
  localparam logic [7:0] DecDigits  = 8'd10;

  // Bits of quotient produced per divider cycle.
  localparam int unsigned DivStep = 4;

  // Digit value of an ASCII character, signed so that characters below '0' wrap.
  function automatic logic signed [9:0] char_value(input logic [7:0] c);
    logic [7:0] f;
    logic [9:0] v;
    f = c;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      f = c + CaseOffset;
    end
    if (f >= CharLowerA) begin
      v = {2'b00, f} - {2'b00, CharLowerA} + {2'b00, DecDigits};
    end else begin
      v = {2'b00, f} - {2'b00, CharZero};
    end
    return signed'(v);
  endfunction

  // ASCII character of one output digit.
  function automatic logic [6:0] digit_char_of(input logic [BaseW-1:0] d);
    logic [6:0] r;
    if ({2'b00, d} < DecDigits) begin
      r = 7'(d) + CharZero[6:0];
    end else begin
      r = 7'(d) + CharUpperA[6:0] - DecDigits[6:0];
    end
    return r;
  endfunction

endpackage

>>> design/rsc_div.sv
// Iterative divider that takes several quotient bits per cycle by a small divisor.
module rsc_div
  import rsc_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ACC_WIDTH-1:0] dividend_i,
  input  logic [BaseW-1:0]     divisor_i,
  output logic                 done_o,
  output logic [ACC_WIDTH-1:0] quotient_o,
  output logic [BaseW-1:0]     remainder_o
);

  localparam int unsigned Iter = (ACC_WIDTH + DivStep - 1) / DivStep;
  localparam int unsigned DW   = Iter * DivStep;
  localparam int unsigned CntW = $clog2(Iter + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [BaseW-1:0] rem_q, rem_d;
  logic [BaseW-1:0] div_q, div_d;

  // Several restoring steps per cycle, plus start and finish control.
  always_comb begin
    logic [BaseW:0]   t;
    logic [BaseW-1:0] r;
    logic [DW-1:0]    q;
    r = rem_q;
    q = quo_q;
    for (int k = 0; k < DivStep; k++) begin
      t = {r, q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
        q[0] = 1'b1;
      end
      r = t[BaseW-1:0];
    end
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (busy_q) begin
      quo_d = q;
      rem_d = r;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Iter);
      quo_d  = DW'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[ACC_WIDTH-1:0];
  assign remainder_o = rem_q;

endmodule

>>> design/radix_string_converter.sv
// Top level of the radix string converter: accumulator, sequencer and digit store.
//
// Input requests carry one ASCII digit and a last flag, valid/stall handshake.
// Each non-last character is folded into the accumulator.
// On a last character the value is divided repeatedly by out_base, taken as
// two if below two; the shared divider gives one remainder digit per division.
// Remainders go to a digit store, then are read back most significant first,
// each digit passing a read state then a write state (registered memory read).
// After a last character the input stalls until the final digit is registered.
// Leading '0' or a zero value gives no output and no stall.
// The result sits in an output register; while the receiver stalls it holds
// and the sequencer waits, and the input may be taken again once the
// sequencer is idle even if the final digit has not yet been taken.
// Configuration is a plain write port; the user must see that it is written
// only while the block is idle, which the block itself does not enforce.
// Reset clears the accumulator and flags and sets both bases to ten.
module radix_string_converter
  import rsc_pkg::*;
#(
  parameter int unsigned ACC_WIDTH      = 32,
  parameter int unsigned MAX_OUT_DIGITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rsc_in_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsc_out_t         out_req_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [BaseW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_OUT_DIGITS + 1);
  localparam int unsigned AW = $clog2(MAX_OUT_DIGITS);

  rsc_state_e state_q, state_d;

  logic [BaseW-1:0]     in_base_q, out_base_q;
  logic [ACC_WIDTH-1:0] acc_q, acc_d;
  logic                 sup_q, sup_d;
  logic                 seen_q, seen_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [BaseW-1:0]     base_q, base_d;
  logic                 out_valid_q, out_valid_d;
  rsc_out_t             out_q, out_d;
  logic [BaseW-1:0]     rd_q;

  logic                    in_acc;
  logic                    sup_now;
  logic [ACC_WIDTH-1:0]    prod;
  logic [ACC_WIDTH-1:0]    acc_next;
  logic [BaseW-1:0]        base_eff;
  logic                    div_start;
  logic [ACC_WIDTH-1:0]    div_dividend;
  logic [BaseW-1:0]        div_divisor;
  logic                    div_done;
  logic [ACC_WIDTH-1:0]    div_quo;
  logic [BaseW-1:0]        div_rem;
  logic                    mem_we;

  logic [BaseW-1:0] mem [MAX_OUT_DIGITS];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_base_q  <= BaseReset;
      out_base_q <= BaseReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgInBase) begin
        in_base_q <= cfg_data_i;
      end else if (cfg_index_i == CfgOutBase) begin
        out_base_q <= cfg_data_i;
      end
    end
  end

  // Multiply-accumulate of the incoming digit.
  assign in_acc   = in_valid_i && !in_stall_o;
  assign sup_now  = seen_q ? sup_q : (in_req_i.digit_char == CharZero);
  assign prod     = acc_q * ACC_WIDTH'(in_base_q);
  assign acc_next = prod + ACC_WIDTH'(char_value(in_req_i.digit_char));
  assign base_eff = (out_base_q < BaseMin) ? BaseMin : out_base_q;

  // The divider starts from the accumulator, then from its own quotient.
  assign div_dividend = (state_q == RSC_IDLE) ? acc_next : div_quo;
  assign div_divisor  = (state_q == RSC_IDLE) ? base_eff : base_q;

  rsc_div #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer: next state and control.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    sup_d       = sup_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      RSC_IDLE: begin
        if (in_acc) begin
          if (!in_req_i.last_in) begin
            acc_d  = acc_next;
            seen_d = 1'b1;
            sup_d  = sup_now;
          end else begin
            acc_d  = '0;
            seen_d = 1'b0;
            sup_d  = 1'b0;
            if (!sup_now && acc_next != '0) begin
              base_d    = base_eff;
              cnt_d     = '0;
              div_start = 1'b1;
              state_d   = RSC_DIV;
            end
          end
        end
      end
      RSC_DIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          if (div_quo == '0 || cnt_q + CW'(1) == CW'(MAX_OUT_DIGITS)) begin
            state_d = RSC_RD;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      RSC_RD: begin
        state_d = RSC_WR;
      end
      RSC_WR: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_d.out_char = digit_char_of(rd_q);
          out_d.last_out = (cnt_q == CW'(1));
          cnt_d          = cnt_q - CW'(1);
          state_d        = (cnt_q == CW'(1)) ? RSC_IDLE : RSC_RD;
        end
      end
      default: begin
        state_d = RSC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= RSC_IDLE;
      acc_q       <= '0;
      sup_q       <= 1'b0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      sup_q       <= sup_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    out_q  <= out_d;
  end

  // Digit store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[AW-1:0]] <= div_rem;
    end
    if (state_q == RSC_RD) begin
      rd_q <= mem[AW'(cnt_q - CW'(1))];
    end
  end

  assign in_stall_o  = (state_q != RSC_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == RSC_DIV)
    else $error("divider finished outside the division state");

  // The digit count never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_OUT_DIGITS))
    else $error("digit count beyond store depth");

  // A last character with a non-zero, unsuppressed value starts a conversion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_req_i.last_in && !sup_now && acc_next != '0 |=> state_q == RSC_DIV)
    else $error("conversion did not start");

  // The final digit of a conversion returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == RSC_WR && !out_valid_q && cnt_q == CW'(1) |=>
      state_q == RSC_IDLE && out_valid_q && out_q.last_out)
    else $error("final digit not flagged");

endmodule
